[design/ffpa_pkg.sv]
// Shared types and constants of the first-fit page allocator.
// Used by every module of the block except ffpa_ram; depends on nothing.
`default_nettype none

package ffpa_pkg;

  localparam int PAGE_SHIFT = 12;
  localparam int PAGE_W     = 20;
  localparam int PAGES_W    = 21;
  localparam int ADDR_W     = 32;
  localparam int ENTRY_W    = PAGE_W + PAGES_W + 1;
  localparam int CFG_W      = 21;

  localparam int MAX_BLOCKS_DEF = 64;

  localparam logic [PAGES_W-1:0] PAGE_SPACE  = 21'h100000;
  localparam logic [PAGE_W-1:0]  BASE_RESET  = 20'd256;
  localparam logic [PAGES_W-1:0] LIMIT_RESET = 21'd16384;

  // Configuration register indexes.
  localparam logic REG_HEAP_BASE  = 1'b0;
  localparam logic REG_HEAP_LIMIT = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOMEM    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  // Table write selections.
  localparam logic [2:0] WR_NONE  = 3'd0;
  localparam logic [2:0] WR_HIT   = 3'd1;
  localparam logic [2:0] WR_SPLIT = 3'd2;
  localparam logic [2:0] WR_BUMP  = 3'd3;
  localparam logic [2:0] WR_MERGE = 3'd4;
  localparam logic [2:0] WR_FREE  = 3'd5;

  // Pending result selections.
  localparam logic [2:0] RES_NONE       = 3'd0;
  localparam logic [2:0] RES_GRANT_HIT  = 3'd1;
  localparam logic [2:0] RES_GRANT_BUMP = 3'd2;
  localparam logic [2:0] RES_FREED      = 3'd3;
  localparam logic [2:0] RES_NOMEM      = 3'd4;
  localparam logic [2:0] RES_NOTFOUND   = 3'd5;

  typedef struct packed {
    logic       load_req;
    logic       idx_clr;
    logic       idx_inc;
    logic [2:0] wr_sel;
    logic [2:0] res_sel;
    logic       f_load;
    logic       merge_acc;
    logic       merged_clr;
    logic       out_load;
  } ffpa_cmd_t;

  typedef struct packed {
    logic is_free;
    logic empty;
    logic idx_last;
    logic alloc_hit;
    logic split_ok;
    logic bump_ok;
    logic free_hit;
    logic merge_hit;
    logic merged;
    logic out_free;
  } ffpa_stat_t;

endpackage

`default_nettype wire

[design/ffpa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module ffpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/ffpa_ctrl.sv]
// Controller of the allocator: sequences table scans, writes and results.
// Depends on ffpa_pkg.
`default_nettype none

module ffpa_ctrl
  import ffpa_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire ffpa_stat_t stat,
  output ffpa_cmd_t       cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_A_RD  = 4'd2;
  localparam logic [3:0] S_A_EV  = 4'd3;
  localparam logic [3:0] S_SPLIT = 4'd4;
  localparam logic [3:0] S_BUMP  = 4'd5;
  localparam logic [3:0] S_F_RD  = 4'd6;
  localparam logic [3:0] S_F_EV  = 4'd7;
  localparam logic [3:0] S_M_RD  = 4'd8;
  localparam logic [3:0] S_M_EV  = 4'd9;
  localparam logic [3:0] S_F_WB  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.wr_sel  = WR_NONE;
    cmd.res_sel = RES_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          cmd.idx_clr  = 1'b1;
          state_next   = S_START;
        end
      end
      S_START: begin
        if (stat.is_free) begin
          if (stat.empty) begin
            cmd.res_sel = RES_NOTFOUND;
            state_next  = S_DONE;
          end else begin
            state_next = S_F_RD;
          end
        end else begin
          state_next = stat.empty ? S_BUMP : S_A_RD;
        end
      end
      S_A_RD: state_next = S_A_EV;
      S_A_EV: begin
        if (stat.alloc_hit) begin
          cmd.wr_sel  = WR_HIT;
          cmd.res_sel = RES_GRANT_HIT;
          state_next  = stat.split_ok ? S_SPLIT : S_DONE;
        end else if (stat.idx_last) begin
          state_next = S_BUMP;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_A_RD;
        end
      end
      S_SPLIT: begin
        cmd.wr_sel = WR_SPLIT;
        state_next = S_DONE;
      end
      S_BUMP: begin
        if (stat.bump_ok) begin
          cmd.wr_sel  = WR_BUMP;
          cmd.res_sel = RES_GRANT_BUMP;
        end else begin
          cmd.res_sel = RES_NOMEM;
        end
        state_next = S_DONE;
      end
      S_F_RD: state_next = S_F_EV;
      S_F_EV: begin
        if (stat.free_hit) begin
          cmd.f_load     = 1'b1;
          cmd.merged_clr = 1'b1;
          cmd.idx_clr    = 1'b1;
          state_next     = S_M_RD;
        end else if (stat.idx_last) begin
          cmd.res_sel = RES_NOTFOUND;
          state_next  = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_F_RD;
        end
      end
      S_M_RD: state_next = S_M_EV;
      S_M_EV: begin
        if (stat.merge_hit) begin
          cmd.wr_sel    = WR_MERGE;
          cmd.merge_acc = 1'b1;
        end
        if (!stat.idx_last) begin
          cmd.idx_inc = 1'b1;
          state_next  = S_M_RD;
        end else if (stat.merged || stat.merge_hit) begin
          // Another pass is needed until one absorbs nothing.
          cmd.merged_clr = 1'b1;
          cmd.idx_clr    = 1'b1;
          state_next     = S_M_RD;
        end else begin
          state_next = S_F_WB;
        end
      end
      S_F_WB: begin
        cmd.wr_sel  = WR_FREE;
        cmd.res_sel = RES_FREED;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[design/ffpa_dp.sv]
// Datapath of the allocator: registers, entry table, compares and result beat.
// Depends on ffpa_pkg and ffpa_ram.
`default_nettype none

module ffpa_dp
  import ffpa_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic              action,
  input  wire logic [ADDR_W-1:0] request_bytes,
  input  wire logic [ADDR_W-1:0] free_address,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [ADDR_W-1:0] granted_address,
  output logic                   ok,
  output logic      [1:0]        status,
  input  wire ffpa_cmd_t         cmd,
  output ffpa_stat_t             stat
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_BLOCKS);

  // Request and configuration registers.
  logic               is_free;
  logic [PAGES_W-1:0] need;
  logic [ADDR_W-1:0]  free_addr;
  logic [PAGES_W-1:0] heap_limit;
  logic [PAGES_W-1:0] heap_next;
  logic [CW-1:0]      count;
  logic [IW-1:0]      idx;

  // Allocation hit and free target registers.
  logic [PAGE_W-1:0]  hit_base;
  logic [PAGES_W-1:0] hit_have;
  logic [IW-1:0]      f_idx;
  logic [PAGE_W-1:0]  f_base;
  logic [PAGES_W-1:0] f_pages;
  logic [PAGES_W:0]   f_end;
  logic               merged;

  // Pending result.
  logic [ADDR_W-1:0]  res_addr;
  logic               res_ok;
  logic [1:0]         res_status;

  // Table port signals.
  logic               we;
  logic [IW-1:0]      waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] rdata;
  logic [PAGE_W-1:0]  rd_base;
  logic [PAGES_W-1:0] rd_pages;
  logic               rd_used;

  logic [ADDR_W:0]    round_sum;
  logic [PAGES_W-1:0] need_calc;
  logic [PAGES_W-1:0] ceil_page;
  logic [PAGE_W-1:0]  split_base;

  ffpa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx),
    .rdata (rdata)
  );

  assign rd_base  = rdata[ENTRY_W-1 -: PAGE_W];
  assign rd_pages = rdata[PAGES_W:1];
  assign rd_used  = rdata[0];

  // Page count of the request, rounded up without wrap; zero asks for one page.
  assign round_sum = {1'b0, request_bytes} + (ADDR_W+1)'(12'hFFF);
  always_comb begin
    need_calc = round_sum[ADDR_W:PAGE_SHIFT];
    if (need_calc == '0) begin
      need_calc = PAGES_W'(1);
    end
  end

  assign ceil_page  = (heap_limit > PAGE_SPACE) ? PAGE_SPACE : heap_limit;
  assign split_base = hit_base + need[PAGE_W-1:0];

  // Status toward the controller.
  always_comb begin
    stat.is_free   = is_free;
    stat.empty     = (count == '0);
    stat.idx_last  = ((CW'(idx) + CW'(1)) >= count);
    stat.alloc_hit = !rd_used && (rd_pages >= need);
    stat.split_ok  = (rd_pages > need) && (count < COUNT_MAX);
    stat.bump_ok   = (count < COUNT_MAX) && (heap_next <= ceil_page) &&
                     (need <= (ceil_page - heap_next));
    stat.free_hit  = rd_used && ({rd_base, 12'h000} == free_addr);
    stat.merge_hit = (idx != f_idx) && !rd_used && (rd_pages != '0) &&
                     ({2'b00, rd_base} == f_end);
    stat.merged    = merged;
    stat.out_free  = !out_valid || out_ready;
  end

  // Table write selection.
  always_comb begin
    we    = 1'b1;
    waddr = idx;
    wdata = {rd_base, rd_pages, rd_used};
    case (cmd.wr_sel)
      WR_HIT:   wdata = {rd_base, stat.split_ok ? need : rd_pages, 1'b1};
      WR_SPLIT: begin
        waddr = count[IW-1:0];
        wdata = {split_base, hit_have - need, 1'b0};
      end
      WR_BUMP:  begin
        waddr = count[IW-1:0];
        wdata = {heap_next[PAGE_W-1:0], need, 1'b1};
      end
      WR_MERGE: wdata = {rd_base, {PAGES_W{1'b0}}, 1'b0};
      WR_FREE:  begin
        waddr = f_idx;
        wdata = {f_base, f_pages, 1'b0};
      end
      default:  we = 1'b0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_limit <= LIMIT_RESET;
      heap_next  <= {1'b0, BASE_RESET};
      count      <= '0;
      merged     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HEAP_BASE: begin
            if (count == '0) begin
              heap_next <= {1'b0, cfg_data[PAGE_W-1:0]};
            end
          end
          REG_HEAP_LIMIT: heap_limit <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.wr_sel == WR_BUMP) begin
        heap_next <= heap_next + need;
      end
      if (cmd.wr_sel == WR_BUMP || cmd.wr_sel == WR_SPLIT) begin
        count <= count + CW'(1);
      end
      if (cmd.merged_clr) begin
        merged <= 1'b0;
      end else if (cmd.merge_acc) begin
        merged <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      is_free   <= action;
      need      <= need_calc;
      free_addr <= free_address;
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IW'(1);
    end
    if (cmd.wr_sel == WR_HIT) begin
      hit_base <= rd_base;
      hit_have <= rd_pages;
    end
    if (cmd.f_load) begin
      f_idx   <= idx;
      f_base  <= rd_base;
      f_pages <= rd_pages;
      f_end   <= {2'b00, rd_base} + {1'b0, rd_pages};
    end else if (cmd.merge_acc) begin
      f_pages <= f_pages + rd_pages;
      f_end   <= f_end + {1'b0, rd_pages};
    end
    case (cmd.res_sel)
      RES_GRANT_HIT: begin
        res_addr <= {rd_base, 12'h000};
        res_ok <= 1'b1;
        res_status <= ST_OK;
      end
      RES_GRANT_BUMP: begin
        res_addr <= {heap_next[PAGE_W-1:0], 12'h000};
        res_ok <= 1'b1;
        res_status <= ST_OK;
      end
      RES_FREED: begin
        res_addr <= '0;
        res_ok <= 1'b1;
        res_status <= ST_OK;
      end
      RES_NOMEM: begin
        res_addr <= '0;
        res_ok <= 1'b0;
        res_status <= ST_NOMEM;
      end
      RES_NOTFOUND: begin
        res_addr <= '0;
        res_ok <= 1'b0;
        res_status <= ST_NOTFOUND;
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      granted_address <= res_addr;
      ok              <= res_ok;
      status          <= res_status;
    end
  end

endmodule

`default_nettype wire

[design/first_fit_page_allocator.sv]
// First-fit page allocator: an allocate or free request takes one beat in and
// gives one result beat out. Each request is served alone. The table is one RAM
// with a registered read port and the scan reads one entry at a time: an allocate
// scans up to the fill count, a free scans to its entry and then makes full merge
// passes over the table until one absorbs nothing. A finished result waits in an
// output register; the next request is taken once it is there.
// The table needs no clearing after reset.
// Depends on ffpa_pkg, ffpa_ctrl and ffpa_dp.
`default_nettype none

module first_fit_page_allocator
  import ffpa_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              action,
  input  wire logic [ADDR_W-1:0] request_bytes,
  input  wire logic [ADDR_W-1:0] free_address,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [ADDR_W-1:0] granted_address,
  output logic                   ok,
  output logic      [1:0]        status
);

  ffpa_cmd_t  cmd;
  ffpa_stat_t stat;

  ffpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffpa_dp #(.MAX_BLOCKS(MAX_BLOCKS)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .action          (action),
    .request_bytes   (request_bytes),
    .free_address    (free_address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .granted_address (granted_address),
    .ok              (ok),
    .status          (status),
    .cmd             (cmd),
    .stat            (stat)
  );

  // A request is served alone: no second beat right after one is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in service");

  // Success and status agree on every result beat.
  a_ok_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ok == (status == ST_OK)))
    else $error("ok and status disagree");

  // A granted address is page aligned and a failure grants nothing.
  a_grant_form: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((granted_address[11:0] == 12'h000) &&
                   (ok || (granted_address == '0))))
    else $error("malformed granted address");

endmodule

`default_nettype wire
